// ===== rtl/pic_pkg.sv =====
`default_nettype none

package pic_pkg;

  // Fixed sizes of the polygon store and the coordinates
  localparam int MAX_VERTICES = 256;
  localparam int COORD_BITS   = 10;

  // Derived widths
  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int SUM_W  = COORD_BITS + IDX_W;
  localparam int VTX_W  = 2 * COORD_BITS;
  localparam int VCNT_W = 9;

  // Edge arithmetic widths (signed unless noted)
  localparam int D_W    = COORD_BITS + 1;          // a, b
  localparam int P_W    = 2 * COORD_BITS;          // xi*yj, xj*yi (unsigned)
  localparam int C_W    = 2 * COORD_BITS + 1;      // c
  localparam int AP_W   = D_W + COORD_BITS + 1;    // a*px, b*py
  localparam int AS_W   = D_W + SUM_W + 1;         // a*sum_x, b*sum_y
  localparam int CN_W   = C_W + CNT_W + 1;         // c*n
  localparam int ACC_W  = CN_W + 2;                // line values

  // Function codes
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]            func;
    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic              inside_res;
    logic [VCNT_W-1:0] vertex_count;
    logic              dropped;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic             clear;
    logic             append;
    logic             start;
    logic             rd_en;
    logic             rd_first;
    logic [IDX_W-1:0] rd_addr;
    logic             load_imm;
    logic             load_query;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             pipe_busy;
    logic             out_stall;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/pic_ram.sv =====
`default_nettype none

module pic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/pic_dp.sv =====
`default_nettype none

module pic_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pic_pkg::in_item_t  in_data,
  input  wire pic_pkg::cmd_t      cmd,
  output pic_pkg::status_t        sts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pic_pkg::out_item_t      out_data
);

  import pic_pkg::*;

  // Polygon state
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] sumx_r, sumx_nxt;
  logic [SUM_W-1:0] sumy_r, sumy_nxt;
  logic             full;
  logic             wr_en;

  // Query point
  logic [COORD_BITS-1:0] px_r, py_r;

  // Vertex stream
  logic [VTX_W-1:0]      rd_data;
  logic                  rd_vld_r, rd_first_r;
  logic [VTX_W-1:0]      prev_r;
  logic [COORD_BITS-1:0] xi, yi, xj, yj;

  // Stage 1: a, b and the two cross products
  logic                  s1_vld_r;
  logic signed [D_W-1:0] a_nxt, b_nxt, a_r, b_r;
  logic [P_W-1:0]        p1_r, p2_r;

  // Stage 2: c and the line products
  logic                   s2_vld_r;
  logic signed [C_W-1:0]  c_s, c_r;
  logic signed [COORD_BITS:0] pxs, pys;
  logic signed [SUM_W:0]  sxs, sys;
  logic signed [CNT_W:0]  ns;
  logic signed [AP_W-1:0] ap, bp, ap_r, bp_r;
  logic signed [AS_W-1:0] as, bs, as_r, bs_r;
  logic signed [CN_W-1:0] cn, cn_r;

  // Stage 3: line values and sign test
  logic signed [ACC_W-1:0] at_point, at_center;
  logic                    pt_neg, pt_pos, ct_neg, ct_pos, opposite;
  logic                    outside_r;

  // Output register
  logic      out_valid_r;
  out_item_t out_data_r;

  // Count and sums update
  assign full  = (count_r == CNT_W'(MAX_VERTICES));
  assign wr_en = cmd.append && !full;

  always_comb begin
    count_nxt = count_r;
    sumx_nxt  = sumx_r;
    sumy_nxt  = sumy_r;
    if (cmd.clear) begin
      count_nxt = '0;
      sumx_nxt  = '0;
      sumy_nxt  = '0;
    end else if (wr_en) begin
      count_nxt = count_r + CNT_W'(1);
      sumx_nxt  = sumx_r + SUM_W'(in_data.coord_x);
      sumy_nxt  = sumy_r + SUM_W'(in_data.coord_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sumx_r  <= '0;
      sumy_r  <= '0;
    end else begin
      count_r <= count_nxt;
      sumx_r  <= sumx_nxt;
      sumy_r  <= sumy_nxt;
    end
  end

  // Vertex store: {y, x} per entry
  pic_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data ({in_data.coord_y, in_data.coord_x}),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_addr),
    .rd_data (rd_data)
  );

  // Latch the query point
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px_r <= in_data.coord_x;
      py_r <= in_data.coord_y;
    end
  end

  // Read tracking; first read of a walk only primes the previous vertex
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      rd_first_r <= 1'b0;
    end else begin
      rd_vld_r   <= cmd.rd_en;
      rd_first_r <= cmd.rd_first;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      prev_r <= rd_data;
    end
  end

  // Edge i -> j: i is the previous vertex, j the one just read
  assign xi = prev_r[COORD_BITS-1:0];
  assign yi = prev_r[VTX_W-1:COORD_BITS];
  assign xj = rd_data[COORD_BITS-1:0];
  assign yj = rd_data[VTX_W-1:COORD_BITS];

  assign a_nxt = $signed({1'b0, yi}) - $signed({1'b0, yj});
  assign b_nxt = $signed({1'b0, xj}) - $signed({1'b0, xi});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= rd_vld_r && !rd_first_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    p1_r <= xi * yj;
    p2_r <= xj * yi;
  end

  // Line products at the point and at the scaled centroid
  assign c_s = $signed({1'b0, p1_r}) - $signed({1'b0, p2_r});
  assign pxs = $signed({1'b0, px_r});
  assign pys = $signed({1'b0, py_r});
  assign sxs = $signed({1'b0, sumx_r});
  assign sys = $signed({1'b0, sumy_r});
  assign ns  = $signed({1'b0, count_r});

  assign ap = a_r * pxs;
  assign bp = b_r * pys;
  assign as = a_r * sxs;
  assign bs = b_r * sys;
  assign cn = c_s * ns;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    c_r  <= c_s;
    ap_r <= ap;
    bp_r <= bp;
    as_r <= as;
    bs_r <= bs;
    cn_r <= cn;
  end

  // Sums and strict sign disagreement; zero counts as inside
  assign at_point  = ACC_W'(ap_r) + ACC_W'(bp_r) + ACC_W'(c_r);
  assign at_center = ACC_W'(as_r) + ACC_W'(bs_r) + ACC_W'(cn_r);

  assign pt_neg   = at_point[ACC_W-1];
  assign pt_pos   = !at_point[ACC_W-1] && (at_point != '0);
  assign ct_neg   = at_center[ACC_W-1];
  assign ct_pos   = !at_center[ACC_W-1] && (at_center != '0);
  assign opposite = (pt_neg && ct_pos) || (pt_pos && ct_neg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outside_r <= 1'b0;
    end else if (cmd.start) begin
      outside_r <= 1'b0;
    end else if (s2_vld_r && opposite) begin
      outside_r <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_imm || cmd.load_query) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_imm) begin
      out_data_r.inside_res   <= 1'b0;
      out_data_r.vertex_count <= VCNT_W'(count_nxt);
      out_data_r.dropped      <= cmd.append && full;
    end else if (cmd.load_query) begin
      out_data_r.inside_res   <= !outside_r;
      out_data_r.vertex_count <= VCNT_W'(count_r);
      out_data_r.dropped      <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.count     = count_r;
  assign sts.pipe_busy = rd_vld_r || s1_vld_r || s2_vld_r;
  assign sts.out_stall = out_valid_r && !out_ready;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count above capacity");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> !sts.pipe_busy)
    else $error("append while edge pipeline busy");

  a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_query |-> !sts.pipe_busy && !s2_vld_r)
    else $error("query result taken before pipeline drained");
`endif

endmodule

`default_nettype wire

// ===== rtl/pic_ctrl.sv =====
`default_nettype none

module pic_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [1:0]       in_func,
  output logic                  in_ready,
  input  wire pic_pkg::status_t sts,
  output pic_pkg::cmd_t         cmd
);

  import pic_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             accept;

  // State and read index registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_idx_r <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  assign accept = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = !sts.out_stall;
        if (accept) begin
          unique case (in_func)
            FUNC_CLEAR: begin
              cmd.clear    = 1'b1;
              cmd.load_imm = 1'b1;
            end
            FUNC_APPEND: begin
              cmd.append   = 1'b1;
              cmd.load_imm = 1'b1;
            end
            FUNC_QUERY: begin
              cmd.start  = 1'b1;
              rd_idx_nxt = '0;
              // empty polygon goes straight to an inside result
              state_nxt  = (sts.count == '0) ? ST_DONE : ST_WALK;
            end
            default: begin
              cmd.load_imm = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        // reads 0 .. n-1, then vertex 0 again for the closing edge
        cmd.rd_en    = 1'b1;
        cmd.rd_first = (rd_idx_r == '0);
        cmd.rd_addr  = (rd_idx_r == sts.count) ? '0 : rd_idx_r[IDX_W-1:0];
        rd_idx_nxt   = rd_idx_r + CNT_W'(1);
        if (rd_idx_r == sts.count) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_stall) begin
          cmd.load_query = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (sts.count != '0))
    else $error("edge walk on empty polygon");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (CNT_W'(cmd.rd_addr) < sts.count))
    else $error("read beyond stored vertices");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("input ready during query");
`endif

endmodule

`default_nettype wire

// ===== rtl/point_in_convex_polygon.sv =====
`default_nettype none

// Channel  Direction  Ports                           Payload
// in       input      in_valid, in_ready, in_data     in_item_t: func, coord_x, coord_y
// out      output     out_valid, out_ready, out_data  out_item_t: inside_res, vertex_count,
//                                                      dropped
//
// Clear, append and unused codes: result is registered at the transfer edge.
// Query on n >= 1 stored vertices: result registered after n + 1 reads of the vertex RAM's read
// port (one edge per cycle), the drain of the three-stage edge pipeline and the done state;
// an empty polygon goes straight from the transfer to the done state.
// One item at a time; in_ready is low while a query walks the polygon.
// Reset (rst_n, synchronous) empties the polygon; the vertex RAM is not cleared.
// A result held by out_ready low keeps in_ready low and holds back a finished query result.

module point_in_convex_polygon (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pic_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pic_pkg::out_item_t      out_data
);

  import pic_pkg::*;

  cmd_t    cmd;
  status_t sts;

  pic_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pic_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
